[rtl/bfha_pkg.sv]
// Shared types and constants for the best-fit heap allocator.
// No dependencies; bfha_alu and the top level refer to it by scoped names.
package bfha_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam int SIZE_WIDTH = 24;
  localparam int HDR_WIDTH  = 7;
  localparam int CFG_WIDTH  = 32;
  // working width of the shared adder: widest operand plus two carry bits
  localparam int UNIT_WIDTH = ADDR_WIDTH + 2;

  localparam logic [0:0] OP_ALLOC = 1'b0;
  localparam logic [0:0] OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  localparam logic [0:0] REG_HEADER_SIZE = 1'b0;
  localparam logic [0:0] REG_HEAP_LIMIT  = 1'b1;

  typedef struct packed {
    logic [0:0]            op;
    logic [SIZE_WIDTH-1:0] req_size;
    logic [ADDR_WIDTH-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] result_addr;
    logic [SIZE_WIDTH-1:0] granted_size;
    logic [1:0]            status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] start;
    logic [SIZE_WIDTH-1:0] size;
  } seg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD, S_A_EV, S_A_EXACT, S_A_END, S_A_SPL, S_A_SPL2, S_A_HEAP,
    S_D_RD, S_D_WR,
    S_F_ST, S_F_RD, S_F_EV, S_F_PV, S_F_PV2, S_F_PN, S_F_PN2, S_F_NX, S_F_NX2,
    S_I_RD, S_I_WR,
    S_FIN
  } state_t;

endpackage

[rtl/bfha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfha_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bfha_alu.sv]
// Shared three-operand add/subtract unit used by the allocator sequencer.
// Depends on bfha_pkg for the working width.
module bfha_alu (
  input  logic [bfha_pkg::UNIT_WIDTH-1:0] a,
  input  logic [bfha_pkg::UNIT_WIDTH-1:0] b,
  input  logic [bfha_pkg::UNIT_WIDTH-1:0] c,
  input  logic                            sub,
  output logic [bfha_pkg::UNIT_WIDTH-1:0] res
);

  // a - b - c, or a + b + c, modulo the working width
  assign res = sub ? (a - b - c) : (a + b + c);

endmodule

[rtl/best_fit_heap_allocator.sv]
// Top level of the best-fit heap allocator: sequencer, shared adder and segment RAM.
// Depends on bfha_pkg, bfha_alu and bfha_ram.
//
// Free memory is an address-sorted table of up to FREE_ENTRIES segments held in a
// single RAM with registered read. Every request is one beat in and one beat out.
// An allocate scans the table entry by entry, taking the first exact fit or the
// smallest larger segment, else bumping the heap top. A free scans to its
// insertion point, then merges with its neighbours or shifts the tail of the
// table down one entry at a time. Removing an entry shifts the tail up the same
// way. The input is ready only while the sequencer is idle; a finished result
// waits in an output register, so the next request may be taken before it is
// collected. The table needs no clearing after reset: only entries below the
// fill count are ever used. The user must write configuration only while the
// block is idle; the block itself does not enforce this.
module best_fit_heap_allocator #(
  parameter int FREE_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bfha_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bfha_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [bfha_pkg::CFG_WIDTH-1:0]  cfg_data
);

  localparam int AW = bfha_pkg::ADDR_WIDTH;
  localparam int SW = bfha_pkg::SIZE_WIDTH;
  localparam int UW = bfha_pkg::UNIT_WIDTH;
  localparam int IW = $clog2(FREE_ENTRIES);
  localparam int CW = $clog2(FREE_ENTRIES + 1);
  localparam int EW = $bits(bfha_pkg::seg_t);

  bfha_pkg::state_t state, state_next;

  // configuration
  logic [bfha_pkg::HDR_WIDTH-1:0] hdr;
  logic [bfha_pkg::CFG_WIDTH-1:0] heap_limit;

  // persistent allocator state
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] heap_top, heap_top_next;

  // request and working registers
  bfha_pkg::req_t req;
  logic [CW-1:0]  idx, idx_next;
  logic           best_have, best_have_next;
  logic [CW-1:0]  best_idx, best_idx_next;
  bfha_pkg::seg_t best, best_next;
  logic [SW-1:0]  best_diff, best_diff_next;
  logic           prev_have, prev_have_next;
  bfha_pkg::seg_t prev, prev_next;
  logic           nxt_have, nxt_have_next;
  bfha_pkg::seg_t nxt, nxt_next;
  logic [AW-1:0]  st, st_next;
  logic [SW-1:0]  split_size, split_size_next;
  logic           hit, hit_next;
  bfha_pkg::rsp_t res, res_next;
  bfha_pkg::rsp_t out_next;
  logic           out_valid_next;

  // shared adder operands
  logic [UW-1:0] u_a, u_b, u_c, u_res;
  logic          u_sub;

  // RAM port
  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  bfha_pkg::seg_t ram_wseg, ram_rseg;
  logic [EW-1:0]  ram_rdata;

  logic [AW-1:0] lim;
  logic [UW-1:0] hdr_u;

  assign ram_rseg = bfha_pkg::seg_t'(ram_rdata);
  assign lim      = AW'(heap_limit);
  assign hdr_u    = UW'(hdr);
  assign in_ready = (state == bfha_pkg::S_IDLE);

  bfha_alu u_alu (
    .a  (u_a),
    .b  (u_b),
    .c  (u_c),
    .sub(u_sub),
    .res(u_res)
  );

  bfha_ram #(
    .WIDTH(EW),
    .DEPTH(FREE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wseg),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // configuration writes: plain register file
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr        <= bfha_pkg::HDR_WIDTH'(24);
      heap_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        bfha_pkg::REG_HEADER_SIZE: hdr        <= cfg_data[bfha_pkg::HDR_WIDTH-1:0];
        bfha_pkg::REG_HEAP_LIMIT:  heap_limit <= cfg_data;
        default:                   hdr        <= hdr;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfha_pkg::S_IDLE;
      count     <= '0;
      heap_top  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      heap_top  <= heap_top_next;
      out_valid <= out_valid_next;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    idx        <= idx_next;
    best_have  <= best_have_next;
    best_idx   <= best_idx_next;
    best       <= best_next;
    best_diff  <= best_diff_next;
    prev_have  <= prev_have_next;
    prev       <= prev_next;
    nxt_have   <= nxt_have_next;
    nxt        <= nxt_next;
    st         <= st_next;
    split_size <= split_size_next;
    hit        <= hit_next;
    res        <= res_next;
    out_data   <= out_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    heap_top_next   = heap_top;
    idx_next        = idx;
    best_have_next  = best_have;
    best_idx_next   = best_idx;
    best_next       = best;
    best_diff_next  = best_diff;
    prev_have_next  = prev_have;
    prev_next       = prev;
    nxt_have_next   = nxt_have;
    nxt_next        = nxt;
    st_next         = st;
    split_size_next = split_size;
    hit_next        = hit;
    res_next        = res;
    out_next        = out_data;
    out_valid_next  = out_valid;
    u_a             = '0;
    u_b             = '0;
    u_c             = '0;
    u_sub           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = idx[IW-1:0];
    ram_wseg        = '0;
    ram_raddr       = idx[IW-1:0];

    // drop the beat once the consumer takes it
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      bfha_pkg::S_IDLE: begin
        if (in_valid) begin
          res_next       = '0;
          idx_next       = '0;
          best_have_next = 1'b0;
          prev_have_next = 1'b0;
          nxt_have_next  = 1'b0;
          state_next     = (in_data.op == bfha_pkg::OP_FREE) ? bfha_pkg::S_F_ST
                                                             : bfha_pkg::S_A_RD;
        end
      end

      // allocate: scan the table
      bfha_pkg::S_A_RD: begin
        ram_raddr  = idx[IW-1:0];
        state_next = (idx == count) ? bfha_pkg::S_A_END : bfha_pkg::S_A_EV;
      end

      bfha_pkg::S_A_EV: begin
        u_a   = UW'(ram_rseg.size);
        u_c   = UW'(req.req_size);
        u_sub = 1'b1;
        if (ram_rseg.size == req.req_size) begin
          best_next     = ram_rseg;
          best_idx_next = idx;
          state_next    = bfha_pkg::S_A_EXACT;
        end else begin
          if (ram_rseg.size > req.req_size && (!best_have || u_res[SW-1:0] < best_diff)) begin
            best_have_next = 1'b1;
            best_idx_next  = idx;
            best_next      = ram_rseg;
            best_diff_next = u_res[SW-1:0];
          end
          idx_next   = idx + 1'b1;
          state_next = bfha_pkg::S_A_RD;
        end
      end

      bfha_pkg::S_A_EXACT: begin
        u_a                   = UW'(best.start);
        u_b                   = hdr_u;
        res_next.result_addr  = u_res[AW-1:0];
        res_next.granted_size = req.req_size;
        idx_next              = best_idx;
        state_next            = bfha_pkg::S_D_RD;
      end

      bfha_pkg::S_A_END: begin
        if (best_have) begin
          u_a                  = UW'(best.start);
          u_b                  = hdr_u;
          res_next.result_addr = u_res[AW-1:0];
          state_next           = bfha_pkg::S_A_SPL;
        end else begin
          // heap bump: new top = top + header + size
          u_a        = UW'(heap_top);
          u_b        = hdr_u;
          u_c        = UW'(req.req_size);
          st_next    = u_res[AW-1:0];
          hit_next   = (u_res[UW-1:AW] != '0) || (u_res[AW-1:0] > lim);
          state_next = bfha_pkg::S_A_HEAP;
        end
      end

      bfha_pkg::S_A_SPL: begin
        u_a   = UW'(best.size);
        u_b   = hdr_u;
        u_c   = UW'(req.req_size);
        u_sub = 1'b1;
        if (!u_res[UW-1] && u_res != '0) begin
          split_size_next = u_res[SW-1:0];
          state_next      = bfha_pkg::S_A_SPL2;
        end else begin
          res_next.granted_size = best.size;
          idx_next              = best_idx;
          state_next            = bfha_pkg::S_D_RD;
        end
      end

      bfha_pkg::S_A_SPL2: begin
        u_a                   = UW'(best.start);
        u_b                   = hdr_u;
        u_c                   = UW'(req.req_size);
        ram_we                = 1'b1;
        ram_waddr             = best_idx[IW-1:0];
        ram_wseg.start        = u_res[AW-1:0];
        ram_wseg.size         = split_size;
        res_next.granted_size = req.req_size;
        state_next            = bfha_pkg::S_FIN;
      end

      bfha_pkg::S_A_HEAP: begin
        if (hit) begin
          res_next.status = bfha_pkg::ST_OOM;
        end else begin
          u_a                   = UW'(heap_top);
          u_b                   = hdr_u;
          res_next.result_addr  = u_res[AW-1:0];
          res_next.granted_size = req.req_size;
          heap_top_next         = st;
        end
        state_next = bfha_pkg::S_FIN;
      end

      // remove entry idx: move the tail up one place
      bfha_pkg::S_D_RD: begin
        if (CW'(idx + 1'b1) >= count) begin
          count_next = count - 1'b1;
          state_next = bfha_pkg::S_FIN;
        end else begin
          ram_raddr  = IW'(idx + 1'b1);
          state_next = bfha_pkg::S_D_WR;
        end
      end

      bfha_pkg::S_D_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[IW-1:0];
        ram_wseg   = ram_rseg;
        idx_next   = idx + 1'b1;
        state_next = bfha_pkg::S_D_RD;
      end

      // free: segment start is user address less header
      bfha_pkg::S_F_ST: begin
        u_a        = UW'(req.block_addr);
        u_b        = hdr_u;
        u_sub      = 1'b1;
        st_next    = u_res[AW-1:0];
        state_next = bfha_pkg::S_F_RD;
      end

      bfha_pkg::S_F_RD: begin
        ram_raddr  = idx[IW-1:0];
        state_next = (idx == count) ? bfha_pkg::S_F_PV : bfha_pkg::S_F_EV;
      end

      bfha_pkg::S_F_EV: begin
        if (ram_rseg.start <= st) begin
          prev_next      = ram_rseg;
          prev_have_next = 1'b1;
          idx_next       = idx + 1'b1;
          state_next     = bfha_pkg::S_F_RD;
        end else begin
          nxt_next      = ram_rseg;
          nxt_have_next = 1'b1;
          state_next    = bfha_pkg::S_F_PV;
        end
      end

      bfha_pkg::S_F_PV: begin
        u_a        = UW'(prev.start);
        u_b        = hdr_u;
        u_c        = UW'(prev.size);
        hit_next   = prev_have && (u_res[AW-1:0] == st);
        state_next = bfha_pkg::S_F_PV2;
      end

      bfha_pkg::S_F_PV2: begin
        u_a = UW'(prev.size);
        u_b = hdr_u;
        u_c = UW'(req.req_size);
        if (hit && u_res[UW-1:SW] == '0) begin
          prev_next.size = u_res[SW-1:0];
          state_next     = bfha_pkg::S_F_PN;
        end else begin
          state_next = bfha_pkg::S_F_NX;
        end
      end

      bfha_pkg::S_F_PN: begin
        u_a        = UW'(prev.start);
        u_b        = hdr_u;
        u_c        = UW'(prev.size);
        hit_next   = nxt_have && (u_res[AW-1:0] == nxt.start);
        state_next = bfha_pkg::S_F_PN2;
      end

      bfha_pkg::S_F_PN2: begin
        u_a            = UW'(prev.size);
        u_b            = hdr_u;
        u_c            = UW'(nxt.size);
        ram_we         = 1'b1;
        ram_waddr      = IW'(idx - 1'b1);
        ram_wseg.start = prev.start;
        if (hit && u_res[UW-1:SW] == '0) begin
          // bridge both neighbours, then remove the following entry
          ram_wseg.size = u_res[SW-1:0];
          state_next    = bfha_pkg::S_D_RD;
        end else begin
          ram_wseg.size = prev.size;
          state_next    = bfha_pkg::S_FIN;
        end
      end

      bfha_pkg::S_F_NX: begin
        u_a        = UW'(st);
        u_b        = hdr_u;
        u_c        = UW'(req.req_size);
        hit_next   = nxt_have && (u_res[AW-1:0] == nxt.start);
        state_next = bfha_pkg::S_F_NX2;
      end

      bfha_pkg::S_F_NX2: begin
        u_a = UW'(req.req_size);
        u_b = hdr_u;
        u_c = UW'(nxt.size);
        if (hit && u_res[UW-1:SW] == '0) begin
          ram_we         = 1'b1;
          ram_waddr      = idx[IW-1:0];
          ram_wseg.start = st;
          ram_wseg.size  = u_res[SW-1:0];
          state_next     = bfha_pkg::S_FIN;
        end else if (count == CW'(FREE_ENTRIES)) begin
          res_next.status = bfha_pkg::ST_TABLE_FULL;
          state_next      = bfha_pkg::S_FIN;
        end else begin
          best_idx_next = count;
          state_next    = bfha_pkg::S_I_RD;
        end
      end

      // insert at idx: move the tail down one place, from the end
      bfha_pkg::S_I_RD: begin
        if (best_idx == idx) begin
          ram_we         = 1'b1;
          ram_waddr      = idx[IW-1:0];
          ram_wseg.start = st;
          ram_wseg.size  = req.req_size;
          count_next     = count + 1'b1;
          state_next     = bfha_pkg::S_FIN;
        end else begin
          ram_raddr  = IW'(best_idx - 1'b1);
          state_next = bfha_pkg::S_I_WR;
        end
      end

      bfha_pkg::S_I_WR: begin
        ram_we        = 1'b1;
        ram_waddr     = best_idx[IW-1:0];
        ram_wseg      = ram_rseg;
        best_idx_next = best_idx - 1'b1;
        state_next    = bfha_pkg::S_I_RD;
      end

      // hold the result until the output register is free
      bfha_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          out_next       = res;
          out_valid_next = 1'b1;
          state_next     = bfha_pkg::S_IDLE;
        end
      end

      default: state_next = bfha_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FREE_ENTRIES))
    else $error("segment count past table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again straight after an accepted beat");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ram_we)
    else $error("table written while idle");

  a_result_on_finish: assert property (@(posedge clk) disable iff (rst)
    state == bfha_pkg::S_FIN && (!out_valid || out_ready) |=> out_valid && in_ready)
    else $error("finished request did not post a result");
`endif

endmodule
